### rtl/ovss_pkg.sv
// types and constants for the oom victim score selector
// no dependencies
`default_nettype none
package ovss_pkg;

  localparam int SQ_W      = 38;
  localparam int SQ_STEPS  = 19;
  localparam int ROOT_W    = 19;
  localparam int SQREM_W   = 20;
  localparam int PTS_W     = 41;
  localparam int DIV_STEPS = 41;
  localparam int SCORE_W   = 48;
  localparam int IDX_W     = 12;
  localparam int SHIFT_W   = 58;
  localparam int CNT_W     = 6;
  localparam int IN_DATA_W = 152;
  localparam int IN_USER_W = 6;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_CPU,
    S_DIV_CPU,
    S_SQ_RUN1,
    S_SQ_RUN2,
    S_DIV_RUN,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    DEC_OPEN = 2'd0,
    DEC_WAIT = 2'd1,
    DEC_SWAP = 2'd2
  } decided_e;

  typedef enum logic [1:0] {
    ST_VICTIM  = 2'd0,
    ST_WAIT    = 2'd1,
    ST_SWAPOFF = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

endpackage
`default_nettype wire

### rtl/oom_victim_score_select.sv
// oom victim selection over a scan of task descriptors, bit-serial root and divide
// depends on ovss_pkg
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata task fields, tuser flags, tlast end of scan
// m_axis    out  tvalid/tready          tdata index and score, tuser status
// cfg       in   cfg_valid_i/cfg_ready_o cfg_data_i uptime in seconds
//
// a scored task takes 3*19 root steps plus up to 2*41 divide steps
// the root unit and the divide unit are each shared and produce one bit per cycle
// skipped, dying or memoryless tasks go from idle straight to the final state, with no root or divide
// reset clears the scan state and the uptime register
// the last beat of a scan waits in the final state until the result register is free
`default_nettype none
module oom_victim_score_select
  import ovss_pkg::*;
#(
  parameter int MAX_TASKS = 4096,
  parameter int CPU_SHIFT = 13,
  parameter int RUN_SHIFT = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // own_vm, children_vm, cpu_ticks, start_sec, oom_adj, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // nice_positive, admin_or_root, raw_io, dying, swapoff, is_init
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // victim_index, victim_score, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic [1:0]                 m_axis_tuser,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [31:0]           cfg_data_i
);

  localparam int PW = $clog2(MAX_TASKS);

  state_e state_q, state_d;
  decided_e dec_q, dec_d;
  logic [31:0] uptime_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] best_idx_q, best_idx_d;
  logic [SCORE_W-1:0] best_q, best_d;
  logic have_q, have_d;
  logic out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [1:0] out_user_q;

  logic [PTS_W-1:0] pts_q;
  logic [SQ_W-1:0] sq_x_q;
  logic [SQREM_W-1:0] sq_rem_q, dv_rem_q;
  logic [ROOT_W-1:0] sq_root_q;
  logic [31:0] run_q;
  logic nice_q, admin_q, raw_q, dying_q, swap_q, init_q, last_q;
  logic [4:0] adj_q;

  logic acc;
  logic [39:0] cpu_sh;
  logic [32:0] up_diff;
  logic [31:0] run_new;
  logic needs_score;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign cpu_sh = s_axis_tdata[111:72] >> CPU_SHIFT;
  assign up_diff = {1'b0, uptime_q} - {1'b0, s_axis_tdata[143:112]};
  assign run_new = up_diff[32] ? 32'd0 : (up_diff[31:0] >> RUN_SHIFT);
  assign needs_score = (dec_q == DEC_OPEN) && !s_axis_tuser[5] && !s_axis_tuser[3]
                       && (s_axis_tdata[31:0] != 32'd0);

  // root step
  logic [SQREM_W+1:0] sq_sh, sq_trial;
  logic sq_ge;
  logic [ROOT_W-1:0] root_d;
  logic [SQREM_W-1:0] sq_rem_d;
  logic sq_done;
  assign sq_sh = {sq_rem_q, sq_x_q[SQ_W-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};
  assign sq_ge = sq_sh >= sq_trial;
  assign root_d = {sq_root_q[ROOT_W-2:0], sq_ge};
  assign sq_rem_d = sq_ge ? SQREM_W'(sq_sh - sq_trial) : sq_sh[SQREM_W-1:0];
  assign sq_done = cnt_q == CNT_W'(SQ_STEPS - 1);

  // divide step
  logic [SQREM_W:0] dv_sh, dv_den;
  logic dv_ge;
  logic [SQREM_W-1:0] dv_rem_d;
  logic dv_done;
  assign dv_sh = {dv_rem_q, pts_q[PTS_W-1]};
  assign dv_den = (SQREM_W+1)'(sq_root_q);
  assign dv_ge = dv_sh >= dv_den;
  assign dv_rem_d = dv_ge ? SQREM_W'(dv_sh - dv_den) : dv_sh[SQREM_W-1:0];
  assign dv_done = cnt_q == CNT_W'(DIV_STEPS - 1);

  // score modifiers
  logic [PTS_W:0] p1, p2, p3;
  logic [4:0] rsh;
  logic [SHIFT_W-1:0] pw;
  logic [SCORE_W-1:0] score;
  assign p1 = nice_q ? {pts_q, 1'b0} : {1'b0, pts_q};
  assign p2 = admin_q ? (p1 >> 2) : p1;
  assign p3 = raw_q ? (p2 >> 2) : p2;
  assign rsh = 5'(5'd0 - adj_q);
  assign pw = adj_q[4] ? SHIFT_W'(p3 >> rsh) : (SHIFT_W'(p3) << adj_q[3:0]);
  assign score = (|pw[SHIFT_W-1:SCORE_W]) ? {SCORE_W{1'b1}} : pw[SCORE_W-1:0];

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) state_d = needs_score ? S_SQ_CPU : S_FIN;
      end
      S_SQ_CPU: begin
        if (sq_done) state_d = (root_d == '0) ? S_SQ_RUN1 : S_DIV_CPU;
      end
      S_DIV_CPU: begin
        if (dv_done) state_d = S_SQ_RUN1;
      end
      S_SQ_RUN1: begin
        if (sq_done) state_d = S_SQ_RUN2;
      end
      S_SQ_RUN2: begin
        if (sq_done) state_d = (root_d == '0) ? S_FIN : S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (dv_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (!last_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    cfg_ready_o   = 1'b1;
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = out_data_q;
    m_axis_tuser  = out_user_q;
  end

  // scan bookkeeping on the final state
  logic commit;
  assign commit = (state_q == S_FIN) && (!last_q || out_free);
  always_comb begin
    dec_d = dec_q;
    best_d = best_q;
    best_idx_d = best_idx_q;
    have_d = have_q;
    pos_d = (pos_q == PW'(MAX_TASKS - 1)) ? '0 : pos_q + 1'b1;
    if (dec_q == DEC_OPEN && !init_q) begin
      if (dying_q) begin
        dec_d = DEC_WAIT;
        best_d = '0;
        best_idx_d = '0;
      end else if (swap_q) begin
        dec_d = DEC_SWAP;
        best_d = score;
        best_idx_d = pos_q;
        have_d = 1'b1;
      end else if (!have_q || score > best_q) begin
        best_d = score;
        best_idx_d = pos_q;
        have_d = 1'b1;
      end
    end
  end

  logic [PW+IDX_W-1:0] idx_ext;
  logic [1:0] res_status;
  logic [OUT_DATA_W-1:0] res_data;
  assign idx_ext = {{IDX_W{1'b0}}, best_idx_d};
  always_comb begin
    case (dec_d)
      DEC_WAIT: res_status = ST_WAIT;
      DEC_SWAP: res_status = ST_SWAPOFF;
      default:  res_status = have_d ? ST_VICTIM : ST_NONE;
    endcase
    if (res_status == ST_WAIT || res_status == ST_NONE) begin
      res_data = '0;
    end else begin
      res_data = {{(OUT_DATA_W-SCORE_W-IDX_W){1'b0}}, best_d, idx_ext[IDX_W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dec_q       <= DEC_OPEN;
      uptime_q    <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      best_idx_q  <= '0;
      best_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) uptime_q <= cfg_data_i;
      if (state_q != state_d) cnt_q <= '0;
      else cnt_q <= cnt_q + 1'b1;
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      if (commit) begin
        if (last_q) begin
          out_valid_q <= 1'b1;
          dec_q <= DEC_OPEN;
          best_q <= '0;
          best_idx_q <= '0;
          have_q <= 1'b0;
          pos_q <= '0;
        end else begin
          dec_q <= dec_d;
          best_q <= best_d;
          best_idx_q <= best_idx_d;
          have_q <= have_d;
          pos_q <= pos_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && last_q) begin
      out_data_q <= res_data;
      out_user_q <= res_status;
    end
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          pts_q    <= (s_axis_tdata[31:0] == 32'd0) ? '0
                      : PTS_W'(s_axis_tdata[31:0]) + PTS_W'(s_axis_tdata[71:32]);
          sq_x_q   <= cpu_sh[SQ_W-1:0];
          sq_rem_q <= '0;
          sq_root_q <= '0;
          run_q    <= run_new;
          adj_q    <= s_axis_tdata[148:144];
          nice_q   <= s_axis_tuser[0];
          admin_q  <= s_axis_tuser[1];
          raw_q    <= s_axis_tuser[2];
          dying_q  <= s_axis_tuser[3];
          swap_q   <= s_axis_tuser[4];
          init_q   <= s_axis_tuser[5];
          last_q   <= s_axis_tlast;
        end
      end
      S_SQ_CPU, S_SQ_RUN1, S_SQ_RUN2: begin
        sq_x_q    <= sq_x_q << 2;
        sq_rem_q  <= sq_rem_d;
        sq_root_q <= root_d;
        dv_rem_q  <= '0;
        if (sq_done && state_q == S_SQ_CPU && root_d == '0) begin
          sq_x_q    <= SQ_W'(run_q);
          sq_rem_q  <= '0;
          sq_root_q <= '0;
        end
        if (sq_done && state_q == S_SQ_RUN1) begin
          sq_x_q    <= SQ_W'(root_d);
          sq_rem_q  <= '0;
          sq_root_q <= '0;
        end
      end
      S_DIV_CPU, S_DIV_RUN: begin
        pts_q    <= {pts_q[PTS_W-2:0], dv_ge};
        dv_rem_q <= dv_rem_d;
        if (dv_done && state_q == S_DIV_CPU) begin
          sq_x_q    <= SQ_W'(run_q);
          sq_rem_q  <= '0;
          sq_root_q <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/ovss_checker.sv
// port-level checks for the oom victim score selector, bound to the top level
// depends on ovss_pkg
`default_nettype none
module ovss_checker
  import ovss_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]            m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_WAIT |-> m_axis_tdata == '0)
    else $error("wait result carries a victim");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_NONE |-> m_axis_tdata == '0)
    else $error("empty result carries a victim");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind oom_victim_score_select ovss_checker u_ovss_checker (.*);
`default_nettype wire
